// File: design/gce_pkg.sv
// gce_pkg: shared types and constants for the glyph color expansion blitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package gce_pkg;

    localparam int PIXELS_PER_BYTE   = 8;
    localparam int MAX_BYTES_PER_ROW = 32;
    localparam int GCE_QUEUE_DEPTH   = 4;

    localparam logic [7:0] TOP_BIT = 8'h80;

    // register index, byte address is 4x
    typedef enum logic [2:0] {
        REG_LINE_PIXELS,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_BYTES_PER_ROW,
        REG_GLYPH_ROWS,
        REG_FG_COLOUR,
        REG_BG_COLOUR
    } gce_reg_t;

    typedef struct packed {
        logic [12:0] line_pixels;
        logic [10:0] origin_x;
        logic [10:0] origin_y;
        logic [5:0]  bytes_per_row;
        logic [7:0]  glyph_rows;
        logic [23:0] fg_colour;
        logic [23:0] bg_colour;
    } gce_cfg_t;

    // one classified font byte, queued between front and back
    typedef struct packed {
        logic [7:0]  bits;
        logic [23:0] row_base;
        logic [11:0] col;
        logic        glyph_end;
    } gce_entry_t;

endpackage

`default_nettype wire

// File: design/glyph_color_expansion_blit.sv
// glyph_color_expansion_blit: top level, APB register bank plus front, queue, back.
// Depends on gce_pkg, gce_front, gce_queue, gce_expand.
//
//   channel  dir  handshake        payload
//   s_       in   s_valid/s_ready  s_font_byte[7:0]
//   m_       out  m_valid/m_ready  m_pixel_index[23:0], m_pixel_colour[23:0],
//                                  m_last_of_byte, m_last_of_glyph
//   apb      in   psel/penable     paddr[4:0], pwdata[31:0], prdata[31:0], pready
//
// Each font byte yields eight pixel writes, one per cycle while m_ready is high;
// that rate is set by the single-pixel output port of the expander.
// An accepted byte passes the queue, the load registers and the output reg before its first pixel leaves.
// The queue holds QUEUE_DEPTH bytes; s_ready drops only when it is full.
// Synchronous active-low reset restores register defaults and clears counters.
`default_nettype none

module glyph_color_expansion_blit import gce_pkg::*; #(
    parameter int QUEUE_DEPTH = GCE_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_font_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_pixel_index,
    output logic [23:0]      m_pixel_colour,
    output logic             m_last_of_byte,
    output logic             m_last_of_glyph
);

    gce_cfg_t   cfg_reg;
    gce_reg_t   reg_sel;
    logic       wr_en;
    logic       q_full;
    logic       push;
    gce_entry_t push_entry;
    logic       pop;
    logic       q_not_empty;
    gce_entry_t q_entry;

    assign pready  = 1'b1;
    assign reg_sel = gce_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_pixels   <= 13'd1024;
            cfg_reg.origin_x      <= 11'd0;
            cfg_reg.origin_y      <= 11'd0;
            cfg_reg.bytes_per_row <= 6'd4;
            cfg_reg.glyph_rows    <= 8'd32;
            cfg_reg.fg_colour     <= 24'h000000;
            cfg_reg.bg_colour     <= 24'hFFFFFF;
        end else if (wr_en) begin
            case (reg_sel)
                REG_LINE_PIXELS:   cfg_reg.line_pixels   <= pwdata[12:0];
                REG_ORIGIN_X:      cfg_reg.origin_x      <= pwdata[10:0];
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= pwdata[10:0];
                REG_BYTES_PER_ROW: cfg_reg.bytes_per_row <= pwdata[5:0];
                REG_GLYPH_ROWS:    cfg_reg.glyph_rows    <= pwdata[7:0];
                REG_FG_COLOUR:     cfg_reg.fg_colour     <= pwdata[23:0];
                REG_BG_COLOUR:     cfg_reg.bg_colour     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LINE_PIXELS:   prdata = {19'b0, cfg_reg.line_pixels};
            REG_ORIGIN_X:      prdata = {21'b0, cfg_reg.origin_x};
            REG_ORIGIN_Y:      prdata = {21'b0, cfg_reg.origin_y};
            REG_BYTES_PER_ROW: prdata = {26'b0, cfg_reg.bytes_per_row};
            REG_GLYPH_ROWS:    prdata = {24'b0, cfg_reg.glyph_rows};
            REG_FG_COLOUR:     prdata = {8'b0, cfg_reg.fg_colour};
            REG_BG_COLOUR:     prdata = {8'b0, cfg_reg.bg_colour};
            default:           prdata = 32'd0;
        endcase
    end

    gce_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_font_byte (s_font_byte),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    gce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .pop_entry  (q_entry)
    );

    gce_expand u_expand (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_not_empty     (q_not_empty),
        .q_entry         (q_entry),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_index   (m_pixel_index),
        .m_pixel_colour  (m_pixel_colour),
        .m_last_of_byte  (m_last_of_byte),
        .m_last_of_glyph (m_last_of_glyph)
    );

endmodule

`default_nettype wire

// File: design/gce_front.sv
// gce_front: accepts font bytes, tracks row/byte position, computes the row base
// and column of each byte. Depends on gce_pkg.
`default_nettype none

module gce_front import gce_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire gce_cfg_t   cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_font_byte,
    input  wire logic       q_full,
    output logic            push,
    output gce_entry_t      push_entry
);

    logic [7:0]  row_count_reg, row_count_next;
    logic [4:0]  byte_count_reg, byte_count_next;
    logic [5:0]  bpr_eff;
    logic [7:0]  rows_eff;
    logic        row_end;
    logic        glyph_end;
    logic [11:0] row_pos;
    logic [24:0] row_product;

    always_comb begin
        if (cfg.bytes_per_row == 6'd0) begin
            bpr_eff = 6'd1;
        end else if (cfg.bytes_per_row > 6'(MAX_BYTES_PER_ROW)) begin
            bpr_eff = 6'(MAX_BYTES_PER_ROW);
        end else begin
            bpr_eff = cfg.bytes_per_row;
        end
        rows_eff = (cfg.glyph_rows == 8'd0) ? 8'd1 : cfg.glyph_rows;
    end

    assign row_end   = {1'b0, byte_count_reg} >= (bpr_eff - 6'd1);
    assign glyph_end = row_end && (row_count_reg >= (rows_eff - 8'd1));

    assign row_pos     = {1'b0, cfg.origin_y} + {4'b0, row_count_reg};
    assign row_product = {13'b0, row_pos} * {12'b0, cfg.line_pixels};

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_entry.bits      = s_font_byte;
        push_entry.row_base  = row_product[23:0];
        push_entry.col       = {1'b0, cfg.origin_x} + {4'b0, byte_count_reg, 3'b000};
        push_entry.glyph_end = glyph_end;
    end

    always_comb begin
        row_count_next  = row_count_reg;
        byte_count_next = byte_count_reg;
        if (push) begin
            if (row_end) begin
                byte_count_next = 5'd0;
                row_count_next  = glyph_end ? 8'd0 : row_count_reg + 8'd1;
            end else begin
                byte_count_next = byte_count_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= 8'd0;
            byte_count_reg <= 5'd0;
        end else begin
            row_count_reg  <= row_count_next;
            byte_count_reg <= byte_count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/gce_queue.sv
// gce_queue: short FIFO of classified font bytes between front and back.
// Depends on gce_pkg.
`default_nettype none

module gce_queue import gce_pkg::*; #(
    parameter int DEPTH = GCE_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire gce_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output gce_entry_t      pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gce_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");

    a_ptr_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg == rd_ptr_reg) == (count_reg == '0 || count_reg == CNT_W'(DEPTH)))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: design/gce_expand.sv
// gce_expand: turns each queued font byte into eight pixel writes, MSB first,
// through a registered output stage. Depends on gce_pkg.
`default_nettype none

module gce_expand import gce_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire gce_cfg_t    cfg,
    input  wire logic        q_not_empty,
    input  wire gce_entry_t  q_entry,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_pixel_index,
    output logic [23:0]      m_pixel_colour,
    output logic             m_last_of_byte,
    output logic             m_last_of_glyph
);

    localparam logic [2:0] LAST_PIX = 3'(PIXELS_PER_BYTE - 1);

    logic        busy_reg;
    logic [7:0]  bits_reg;
    logic [23:0] index_reg;
    logic [2:0]  pix_cnt_reg;
    logic        glyph_end_reg;

    logic        m_valid_reg;
    logic [23:0] m_index_reg;
    logic [23:0] m_colour_reg;
    logic        m_lbyte_reg;
    logic        m_lglyph_reg;

    logic        emit;
    logic        byte_done;

    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign byte_done = emit && (pix_cnt_reg == LAST_PIX);
    assign pop       = q_not_empty && (!busy_reg || byte_done);

    assign m_valid         = m_valid_reg;
    assign m_pixel_index   = m_index_reg;
    assign m_pixel_colour  = m_colour_reg;
    assign m_last_of_byte  = m_lbyte_reg;
    assign m_last_of_glyph = m_lglyph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pix_cnt_reg <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg    <= 1'b1;
                pix_cnt_reg <= 3'd0;
            end else if (byte_done) begin
                busy_reg    <= 1'b0;
                pix_cnt_reg <= 3'd0;
            end else if (emit) begin
                pix_cnt_reg <= pix_cnt_reg + 3'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            bits_reg      <= q_entry.bits;
            index_reg     <= q_entry.row_base + {12'b0, q_entry.col};
            glyph_end_reg <= q_entry.glyph_end;
        end else if (emit) begin
            bits_reg  <= {bits_reg[6:0], 1'b0};
            index_reg <= index_reg + 24'd1;
        end
        if (emit) begin
            m_index_reg  <= index_reg;
            m_colour_reg <= ((bits_reg & TOP_BIT) != 8'd0) ? cfg.fg_colour : cfg.bg_colour;
            m_lbyte_reg  <= (pix_cnt_reg == LAST_PIX);
            m_lglyph_reg <= (pix_cnt_reg == LAST_PIX) && glyph_end_reg;
        end
    end

    a_glyph_implies_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_lglyph_reg |-> m_lbyte_reg)
        else $error("glyph end flagged off a byte boundary");

    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> pix_cnt_reg == 3'd0)
        else $error("pixel counter nonzero while idle");

    a_mid_byte_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && pix_cnt_reg != 3'd0 |-> m_valid_reg)
        else $error("output stage empty in the middle of a byte");

endmodule

`default_nettype wire

// File: tb/glyph_color_expansion_blit_tb.sv
// Self-checking testbench for glyph_color_expansion_blit: font bytes in, eight pixel writes out.
// A directed script, then random register settings and font bytes, checked against a predictor.
// Depends on gce_pkg and the glyph_color_expansion_blit RTL.
`timescale 1ns / 100ps

module glyph_color_expansion_blit_tb;
    import gce_pkg::*;

    localparam int RANDOM_PHASES   = 7;
    localparam int BYTES_PER_PHASE = 33;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;

    // unmapped register slot
    localparam gce_reg_t REG_SPARE = gce_reg_t'(3'd7);

    typedef enum logic {ROW_WRITE, ROW_FONT} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        gce_reg_t    reg_idx;
        logic [31:0] value;
        logic [7:0]  font;
        bit          typed;
        logic [23:0] base;
        logic [23:0] set_c;
        logic [23:0] clr_c;
        bit          g_end;
    } stim_row_t;

    typedef struct {
        logic [23:0] index;
        logic [23:0] colour;
        logic        last_byte;
        logic        last_glyph;
    } pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_font_byte;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_pixel_index;
    logic [23:0] m_pixel_colour;
    logic        m_last_of_byte;
    logic        m_last_of_glyph;

    // extra data riding with the font byte for rows whose result is typed in
    bit          cur_typed;
    logic [23:0] cur_base;
    logic [23:0] cur_set;
    logic [23:0] cur_clr;
    bit          cur_gend;

    bit calm;
    bit hold_go;
    bit hold_done;
    int error_count;

    gce_cfg_t   shadow_cfg;
    logic [7:0] glyph_row;
    logic [4:0] glyph_byte;
    pixel_t     pending_pixels[$];
    stim_row_t  glyph_script[$];

    glyph_color_expansion_blit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_font_byte     (s_font_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_index   (m_pixel_index),
        .m_pixel_colour  (m_pixel_colour),
        .m_last_of_byte  (m_last_of_byte),
        .m_last_of_glyph (m_last_of_glyph)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("glyph_color_expansion_blit_tb NOT OK");
        $finish;
    end

    // Position of the next font byte; returns its first pixel index and glyph end.
    function automatic void advance_glyph_cursor(output logic [23:0] base, output logic g_end);
        int              bpr;
        int              rows;
        logic            row_end;
        longint unsigned wide;
        bpr = (shadow_cfg.bytes_per_row == 0) ? 1 : int'(shadow_cfg.bytes_per_row);
        if (bpr > MAX_BYTES_PER_ROW) bpr = MAX_BYTES_PER_ROW;
        rows = (shadow_cfg.glyph_rows == 0) ? 1 : int'(shadow_cfg.glyph_rows);
        row_end = int'(glyph_byte) >= bpr - 1;
        g_end = row_end && (int'(glyph_row) >= rows - 1);
        wide = longint'(shadow_cfg.origin_x) + PIXELS_PER_BYTE * longint'(glyph_byte)
             + (longint'(shadow_cfg.origin_y) + longint'(glyph_row))
             * longint'(shadow_cfg.line_pixels);
        base = wide[23:0];
        if (row_end) begin
            glyph_byte = '0;
            glyph_row  = g_end ? 8'd0 : glyph_row + 8'd1;
        end else begin
            glyph_byte = glyph_byte + 5'd1;
        end
    endfunction

    function automatic void queue_byte_pixels(logic [23:0] base, logic [7:0] bits,
                                              logic [23:0] set_c, logic [23:0] clr_c,
                                              logic g_end);
        pixel_t px;
        for (int i = 0; i < PIXELS_PER_BYTE; i++) begin
            px.index      = base + 24'(i);
            px.colour     = bits[7 - i] ? set_c : clr_c;
            px.last_byte  = (i == PIXELS_PER_BYTE - 1);
            px.last_glyph = (i == PIXELS_PER_BYTE - 1) && g_end;
            pending_pixels.push_back(px);
        end
    endfunction

    always @(posedge aclk) begin
        logic [23:0] base;
        logic        g_end;
        pixel_t      want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                advance_glyph_cursor(base, g_end);
                if (cur_typed)
                    queue_byte_pixels(cur_base, s_font_byte, cur_set, cur_clr, cur_gend);
                else
                    queue_byte_pixels(base, s_font_byte, shadow_cfg.fg_colour,
                                      shadow_cfg.bg_colour, g_end);
            end
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel transaction with nothing expected: index %h", m_pixel_index);
                    error_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_pixel_index !== want.index) begin
                        $error("pixel_index: expected %h, got %h", want.index, m_pixel_index);
                        error_count++;
                    end
                    if (m_pixel_colour !== want.colour) begin
                        $error("pixel_colour: expected %h, got %h", want.colour, m_pixel_colour);
                        error_count++;
                    end
                    if (m_last_of_byte !== want.last_byte) begin
                        $error("last_of_byte: expected %b, got %b", want.last_byte,
                               m_last_of_byte);
                        error_count++;
                    end
                    if (m_last_of_glyph !== want.last_glyph) begin
                        $error("last_of_glyph: expected %b, got %b", want.last_glyph,
                               m_last_of_glyph);
                        error_count++;
                    end
                end
            end
        end
    end

    // pixel sink: random stalls, plus one long hold-off to back up the input
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        hold_done  = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic apb_write(input gce_reg_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_LINE_PIXELS:   shadow_cfg.line_pixels   = value[12:0];
            REG_ORIGIN_X:      shadow_cfg.origin_x      = value[10:0];
            REG_ORIGIN_Y:      shadow_cfg.origin_y      = value[10:0];
            REG_BYTES_PER_ROW: shadow_cfg.bytes_per_row = value[5:0];
            REG_GLYPH_ROWS:    shadow_cfg.glyph_rows    = value[7:0];
            REG_FG_COLOUR:     shadow_cfg.fg_colour     = value[23:0];
            REG_BG_COLOUR:     shadow_cfg.bg_colour     = value[23:0];
            default: ;
        endcase
    endtask

    task automatic send_font_byte(input stim_row_t row);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_font_byte = row.font;
        cur_typed   = row.typed;
        cur_base    = row.base;
        cur_set     = row.set_c;
        cur_clr     = row.clr_c;
        cur_gend    = row.g_end;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_pixels();
        s_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic void add_write(gce_reg_t idx, logic [31:0] value);
        stim_row_t row;
        row = '{kind: ROW_WRITE, reg_idx: idx, value: value, default: '0};
        glyph_script.push_back(row);
    endfunction

    function automatic void add_font(logic [7:0] font);
        stim_row_t row;
        row = '{kind: ROW_FONT, reg_idx: REG_SPARE, font: font, default: '0};
        glyph_script.push_back(row);
    endfunction

    function automatic void add_known(logic [7:0] font, logic [23:0] base, logic [23:0] set_c,
                                      logic [23:0] clr_c, bit g_end);
        stim_row_t row;
        row = '{kind: ROW_FONT, reg_idx: REG_SPARE, value: '0, font: font, typed: 1'b1,
                base: base, set_c: set_c, clr_c: clr_c, g_end: g_end};
        glyph_script.push_back(row);
    endfunction

    function automatic logic [31:0] random_reg_value(gce_reg_t idx);
        int pick;
        pick = $urandom_range(0, 7);
        case (idx)
            REG_LINE_PIXELS:
                case (pick)
                    0: return 32'd0;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'd1;
                    3: return 32'd4096;
                    default: return $urandom_range(1, 4096);
                endcase
            REG_ORIGIN_X, REG_ORIGIN_Y:
                case (pick)
                    0: return 32'd0;
                    1: return 32'd2047;
                    default: return $urandom_range(0, 2047);
                endcase
            REG_BYTES_PER_ROW:
                case (pick)
                    0: return 32'd0;
                    1: return 32'd32;
                    2: return 32'd63;
                    3: return $urandom_range(1, 32);
                    default: return $urandom_range(1, 4);
                endcase
            REG_GLYPH_ROWS:
                case (pick)
                    0: return 32'd0;
                    1: return 32'd255;
                    2: return $urandom_range(1, 255);
                    default: return $urandom_range(1, 4);
                endcase
            default: return $urandom;
        endcase
    endfunction

    initial begin
        stim_row_t row;
        bit        busy;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_font_byte = '0;
        cur_typed   = 0;
        cur_base    = '0;
        cur_set     = '0;
        cur_clr     = '0;
        cur_gend    = 0;
        calm        = 0;
        hold_go     = 0;
        error_count = 0;
        busy        = 0;
        shadow_cfg  = '{line_pixels: 13'd1024, origin_x: '0, origin_y: '0,
                        bytes_per_row: 6'd4, glyph_rows: 8'd32,
                        fg_colour: 24'h000000, bg_colour: 24'hFFFFFF};
        glyph_row   = '0;
        glyph_byte  = '0;

        // register defaults after reset
        add_known(8'hFF, 24'd0, 24'h000000, 24'hFFFFFF, 0);
        add_known(8'h00, 24'd8, 24'h000000, 24'hFFFFFF, 0);
        add_font(8'h81);
        add_font(8'h3C);
        add_known(8'h7E, 24'd1024, 24'h000000, 24'hFFFFFF, 0);
        // limits lowered mid-glyph
        add_write(REG_BYTES_PER_ROW, 32'd1);
        add_write(REG_GLYPH_ROWS, 32'd1);
        add_font(8'h55);
        add_known(8'hAA, 24'd0, 24'h000000, 24'hFFFFFF, 1);
        // index wraps past 2^24, oversize stride
        add_write(REG_ORIGIN_X, 32'd2047);
        add_write(REG_ORIGIN_Y, 32'd2047);
        add_write(REG_LINE_PIXELS, 32'hFFFF_FFFF);
        add_write(REG_GLYPH_ROWS, 32'd255);
        add_write(REG_FG_COLOUR, 32'hFFFF_FFFF);
        add_write(REG_BG_COLOUR, 32'd0);
        add_font(8'h00);
        add_font(8'hFF);
        // oversize row width, zero rows, zero stride, unmapped register
        add_write(REG_BYTES_PER_ROW, 32'hFFFF_FFFF);
        add_write(REG_GLYPH_ROWS, 32'd0);
        add_write(REG_LINE_PIXELS, 32'd0);
        add_write(REG_FG_COLOUR, 32'hAB12_3456);
        add_write(REG_BG_COLOUR, 32'h00FE_DCBA);
        add_write(REG_SPARE, 32'hFFFF_FFFF);
        add_font(8'h0F);
        add_font(8'hF0);
        add_font(8'h01);
        // zero row width
        add_write(REG_BYTES_PER_ROW, 32'd0);
        add_font(8'h80);
        add_known(8'h7F, 24'd2047, 24'h123456, 24'hFEDCBA, 1);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (glyph_script[i]) begin
            if (glyph_script[i].kind == ROW_WRITE) begin
                if (busy) begin
                    drain_pixels();
                    busy = 0;
                end
                apb_write(glyph_script[i].reg_idx, glyph_script[i].value);
            end else begin
                send_font_byte(glyph_script[i]);
                busy = 1;
            end
        end
        drain_pixels();

        row = '{kind: ROW_FONT, reg_idx: REG_SPARE, default: '0};
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm = (phase == RANDOM_PHASES - 1);
            for (int r = 0; r <= REG_BG_COLOUR; r++)
                apb_write(gce_reg_t'(r), random_reg_value(gce_reg_t'(r)));
            if ($urandom_range(0, 1)) apb_write(REG_SPARE, $urandom);
            if (phase == 0) hold_go = 1;
            for (int n = 0; n < BYTES_PER_PHASE; n++) begin
                if ($urandom_range(0, 7) == 0)
                    row.font = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    row.font = 8'($urandom);
                send_font_byte(row);
            end
            drain_pixels();
        end

        if (error_count == 0)
            $display("glyph_color_expansion_blit_tb OK");
        else
            $display("glyph_color_expansion_blit_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
design/gce_pkg.sv
design/gce_front.sv
design/gce_queue.sv
design/gce_expand.sv
design/glyph_color_expansion_blit.sv
tb/glyph_color_expansion_blit_tb.sv
